@@ rtl/commodity_channel_index_top_defines.svh @@
// assertion macros used by the checker file
`ifndef COMMODITY_CHANNEL_INDEX_TOP_DEFINES_SVH
`define COMMODITY_CHANNEL_INDEX_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCIX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccix check failed");

// next-cycle implication, sampled on clk, off during reset
`define CCIX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccix check failed");

`endif

@@ rtl/ccix_pkg.sv @@
package ccix_pkg;

  localparam int MaxPeriod   = 64;
  localparam int PtrW        = 6;
  localparam int TpW         = 34;
  localparam int SumW        = 40;
  localparam int DevW        = 46;
  localparam int DivW        = 48;
  localparam int RemW        = 50;
  localparam int MulW        = 22;
  localparam int QuoW        = 23;

  localparam logic [6:0]  PeriodReset = 7'd14;
  localparam logic [15:0] ScaleNum    = 16'd51200;
  localparam logic [4:0]  MulTopBit   = 5'd21;
  localparam logic [22:0] PosMax      = 23'd1048575;
  localparam logic [22:0] NegMag      = 23'd1048576;

  // register index decoded from paddr[2]
  localparam logic RegPeriod = 1'b0;

  typedef struct packed {
    logic [31:0] bar_high;
    logic [31:0] bar_low;
    logic [31:0] bar_close;
    logic        replace_last;
  } in_item_t;

  typedef struct packed {
    logic signed [20:0] cci_value;
    logic               cci_ready;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StSum, StDev, StPrep, StShift, StSub, StRound, StFinish
  } state_t;

endpackage

@@ rtl/commodity_channel_index_top.sv @@
// channel   | dir | handshake            | payload
// in        | in  | in_valid / in_stall  | in_item (bar_high, bar_low, bar_close, replace_last)
// out       | out | out_valid / out_stall| out_item (cci_value, cci_ready)
// cfg       | in  | apb psel / penable   | period at byte address 0
//
// each item runs a window sum pass and, once the window is full, a deviation
// pass over the 64-entry window memory, one read port each cycle, then a
// 22-step shift/subtract divider (skipped when the deviation is zero).
// in_stall is high from acceptance until the result is loaded into the output register;
// a result waiting under out_stall does not block acceptance of the next item, but that item waits to finish.
// rst is synchronous; the window memory itself is not cleared.
module commodity_channel_index_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ccix_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ccix_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ccix_pkg::*;

  state_t state, state_next;

  logic [6:0]        period;
  logic [PtrW-1:0]   wp;
  logic [6:0]        bars_seen;
  logic [PtrW-1:0]   slot;
  logic [6:0]        k;
  logic [TpW-1:0]    mem [MaxPeriod];
  logic [TpW-1:0]    rd_data;
  logic [SumW-1:0]   s;
  logic [SumW-1:0]   mul_r;
  logic [SumW-1:0]   diff_r;
  logic [SumW-1:0]   a_r;
  logic              neg_r;
  logic [DevW-1:0]   dev;
  logic [DivW-1:0]   d;
  logic [MulW-1:0]   m;
  logic [RemW-1:0]   r;
  logic [QuoW-1:0]   q;
  logic [4:0]        bitn;
  logic              v1, v2, v3, f1, f2, f3;
  logic signed [20:0] res_value;
  logic              res_ready;

  logic [6:0]        pe, cnt;
  logic              accept, issue, sum_done, dev_done, cfg_wr, rep;
  logic [PtrW-1:0]   rd_addr, slot_w;
  logic [TpW-1:0]    tp3;
  logic [40:0]       prod;
  logic [DivW:0]     d2;
  logic [QuoW-1:0]   qr, neg_q;
  logic [RemW:0]     r2;

  // effective period and entries held
  always_comb begin
    if (period == 7'd0) begin
      pe = 7'd1;
    end else if (period > 7'(MaxPeriod)) begin
      pe = 7'(MaxPeriod);
    end else begin
      pe = period;
    end
    cnt = (bars_seen < pe) ? bars_seen : pe;
  end

  assign accept   = (state == StIdle) && in_valid;
  assign in_stall = (state != StIdle);
  assign tp3      = TpW'(in_item.bar_high) + TpW'(in_item.bar_low) + TpW'(in_item.bar_close);
  assign rep      = in_item.replace_last && (bars_seen != 7'd0);
  assign slot_w   = rep ? wp - PtrW'(1) : wp;
  assign issue    = ((state == StSum) && (k < cnt)) || ((state == StDev) && (k < pe));
  assign rd_addr  = slot - k[PtrW-1:0];
  assign sum_done = (k == cnt) && !v1;
  assign dev_done = (k == pe) && !v1 && !v2 && !v3;
  assign prod     = 41'(pe) * 41'(rd_data);
  assign d2       = {d, 1'b0};
  assign r2       = {r, 1'b0};
  assign qr       = q + ((r2 >= (RemW+1)'(d)) ? QuoW'(1) : QuoW'(0));
  assign neg_q    = (qr > NegMag) ? NegMag : qr;

  // config port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegPeriod);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPeriod) ? 32'(period) : 32'd0;

  // window memory
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[slot_w] <= tp3;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      StIdle:   if (in_valid) state_next = StSum;
      StSum: begin
        if (sum_done) state_next = (cnt == pe) ? StDev : StFinish;
      end
      StDev: begin
        if (dev_done) state_next = (dev == '0) ? StFinish : StPrep;
      end
      StPrep:   state_next = StShift;
      StShift:  state_next = StSub;
      StSub:    state_next = (bitn == 5'd0) ? StRound : StShift;
      StRound:  state_next = StFinish;
      StFinish: if (!out_valid || !out_stall) state_next = StIdle;
      default:  state_next = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PeriodReset;
      wp        <= '0;
      bars_seen <= '0;
      out_valid <= 1'b0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (cfg_wr) period <= pwdata[6:0];
      if (accept && !rep) begin
        wp <= wp + PtrW'(1);
        if (bars_seen < 7'(MaxPeriod)) bars_seen <= bars_seen + 7'd1;
      end
      v1 <= issue;
      v2 <= v1 && (state == StDev);
      v3 <= v2;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == StFinish && (!out_valid || !out_stall)) out_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    f1     <= issue && (k == 7'd0);
    f2     <= f1;
    f3     <= f2;
    mul_r  <= prod[SumW-1:0];
    diff_r <= (mul_r >= s) ? mul_r - s : s - mul_r;
    if (f2) neg_r <= (mul_r < s);
    if (f3) a_r <= diff_r;
    if (issue) k <= k + 7'd1;
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          slot <= slot_w;
          k    <= '0;
          s    <= '0;
        end
      end
      StSum: begin
        if (v1) s <= s + SumW'(rd_data);
        if (sum_done) begin
          k         <= '0;
          dev       <= '0;
          res_value <= '0;
          res_ready <= (cnt == pe);
        end
      end
      StDev: begin
        if (v3) dev <= dev + DevW'(diff_r);
      end
      StPrep: begin
        d    <= DivW'(dev) + DivW'({dev, 1'b0});
        m    <= MulW'(23'(pe) * 23'(ScaleNum));
        r    <= '0;
        q    <= '0;
        bitn <= MulTopBit;
      end
      StShift: begin
        r <= {r[RemW-2:0], 1'b0} + (m[bitn] ? RemW'(a_r) : RemW'(0));
        q <= {q[QuoW-2:0], 1'b0};
      end
      StSub: begin
        if (r >= RemW'(d2)) begin
          r <= r - RemW'(d2);
          q <= q + QuoW'(2);
        end else if (r >= RemW'(d)) begin
          r <= r - RemW'(d);
          q <= q + QuoW'(1);
        end
        if (bitn != 5'd0) bitn <= bitn - 5'd1;
      end
      StRound: begin
        if (neg_r) begin
          res_value <= 21'(QuoW'(0) - neg_q);
        end else begin
          res_value <= (qr > PosMax) ? 21'(PosMax) : 21'(qr);
        end
      end
      StFinish: begin
        if (!out_valid || !out_stall) begin
          out_item.cci_value <= res_value;
          out_item.cci_ready <= res_ready;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/ccix_checker.sv @@
module ccix_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ccix_pkg::out_item_t out_item
);
  import ccix_pkg::*;
`include "commodity_channel_index_top_defines.svh"

  // a stalled result stays offered
  `CCIX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // a stalled result does not change
  `CCIX_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))
  // the block is busy right after taking an item
  `CCIX_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // no value before a full window
  `CCIX_ASSERT_NOW(a_zero_not_ready, out_valid && !out_item.cci_ready,
                   out_item.cci_value == 21'sd0)

endmodule

bind commodity_channel_index_top ccix_checker u_ccix_checker (.*);
